FILE: hw/rtl/base64_stream_codec_core_macros.svh
// Assertion helpers for the Base64 codec.
// Sampled on the rising clock edge, disabled while reset is asserted.
`ifndef BASE64_STREAM_CODEC_CORE_MACROS_SVH
`define BASE64_STREAM_CODEC_CORE_MACROS_SVH

// Same-cycle implication
`define B64SC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define B64SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/b64sc_pkg.sv
package b64sc_pkg;

    // Characters with a special role
    localparam logic [7:0] PadChar   = 8'h3D;  // '='
    localparam logic [7:0] PlusChar  = 8'h2B;  // '+'
    localparam logic [7:0] SlashChar = 8'h2F;  // '/'

    // Direction register values
    localparam logic DirEncode = 1'b0;
    localparam logic DirDecode = 1'b1;

    // Number of '=' for a final group holding 3, 1 or 2 bytes (index count mod 3)
    localparam logic [1:0] PadForRest [3] = '{2'd0, 2'd2, 2'd1};

    // Input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    // Output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       out_last;
        logic       error;
    } t_out;

    // One finished group, handed from the front end to the serializer
    typedef struct packed {
        logic [23:0] bits;     // aligned triple (encode) or gathered group (decode)
        logic        decode;
        logic [1:0]  nres_m1;  // number of results minus one
        logic [1:0]  pads;     // trailing '=' characters (encode)
        logic        last;     // group closes the message
        logic        err;      // error flag for the final result
        logic        bad_len;  // message length not a multiple of four
    } t_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Decoded character: sextet value and out-of-alphabet flag
    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } t_sext;

    // Sextet to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = w + 8'd65;            // 'A'..'Z'
        end else if (v < 6'd52) begin
            c = w + 8'd71;            // 'a'..'z'
        end else if (v < 6'd62) begin
            c = w - 8'd4;             // '0'..'9'
        end else if (v == 6'd62) begin
            c = PlusChar;
        end else begin
            c = SlashChar;
        end
        return c;
    endfunction

    // Alphabet character to sextet; flags anything else
    function automatic t_sext dec_char(input logic [7:0] c);
        t_sext s;
        s.bad = 1'b0;
        s.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = 6'(c - 8'd65);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = 6'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = 6'(c + 8'd4);
        end else if (c == PlusChar) begin
            s.val = 6'd62;
        end else if (c == SlashChar) begin
            s.val = 6'd63;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/b64sc_front.sv
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_wr_en,
    input  logic    i_cfg_wr_data,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in     i_in_data,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_cmd    o_push_cmd
);

    logic        r_dir;
    logic [23:0] r_bits;
    logic [1:0]  r_cnt;
    logic [1:0]  r_pads;
    logic        r_bad;

    logic [23:0] n_bits;
    logic [1:0]  n_cnt;
    logic [1:0]  n_pads;
    logic        n_bad;

    logic        fire;
    logic        eom;
    logic [7:0]  ch;
    t_sext       sx;
    logic        is_pad;
    logic [1:0]  e_cnt;
    logic [23:0] e_bits;
    logic [23:0] d_bits;
    logic [1:0]  d_cnt;
    logic [1:0]  d_pads;
    logic        d_bad;
    logic [1:0]  pad_idx;

    // Accept whenever the queue can take a group
    assign o_in_ready = !i_q_stat.full;
    assign fire       = i_in_valid && o_in_ready;
    assign eom        = i_in_data.end_of_message;
    assign ch         = i_in_data.data_byte;

    // Encode path: shift in a byte
    assign e_bits  = {r_bits[15:0], ch};
    assign e_cnt   = r_cnt + 2'd1;
    assign pad_idx = (e_cnt == 2'd3) ? 2'd0 : e_cnt;

    // Decode path: classify the character and shift in its sextet
    assign sx     = dec_char(ch);
    assign is_pad = (ch == PadChar);
    assign d_bits = {r_bits[17:0], (is_pad ? 6'd0 : sx.val)};
    assign d_cnt  = r_cnt + 2'd1;
    assign d_pads = r_pads + {1'b0, (is_pad && r_cnt >= 2'd2)};
    assign d_bad  = r_bad || (!is_pad && sx.bad);

    // Group completion and the command it produces
    always_comb begin
        n_bits     = r_bits;
        n_cnt      = r_cnt;
        n_pads     = r_pads;
        n_bad      = r_bad;
        o_push     = 1'b0;
        o_push_cmd = '0;
        if (fire) begin
            if (r_dir == DirEncode) begin
                n_bits = e_bits;
                n_cnt  = e_cnt;
                if (e_cnt == 2'd3 || eom) begin
                    o_push = 1'b1;
                    unique case (e_cnt)
                        2'd1:    o_push_cmd.bits = {e_bits[7:0], 16'd0};
                        2'd2:    o_push_cmd.bits = {e_bits[15:0], 8'd0};
                        default: o_push_cmd.bits = e_bits;
                    endcase
                    o_push_cmd.decode  = DirEncode;
                    o_push_cmd.nres_m1 = 2'd3;
                    o_push_cmd.pads    = PadForRest[pad_idx];
                    o_push_cmd.last    = eom;
                    n_bits = '0;
                    n_cnt  = '0;
                    if (eom) begin
                        n_pads = '0;
                        n_bad  = 1'b0;
                    end
                end
            end else begin
                n_bits = d_bits;
                n_cnt  = d_cnt;
                n_pads = d_pads;
                n_bad  = d_bad;
                if (d_cnt != 2'd0) begin
                    // Message ends inside a group: single error result
                    if (eom) begin
                        o_push             = 1'b1;
                        o_push_cmd.decode  = DirDecode;
                        o_push_cmd.nres_m1 = 2'd0;
                        o_push_cmd.last    = 1'b1;
                        o_push_cmd.err     = 1'b1;
                        o_push_cmd.bad_len = 1'b1;
                        n_bits = '0;
                        n_cnt  = '0;
                        n_pads = '0;
                        n_bad  = 1'b0;
                    end
                end else begin
                    o_push             = 1'b1;
                    o_push_cmd.bits    = d_bits;
                    o_push_cmd.decode  = DirDecode;
                    o_push_cmd.nres_m1 = eom ? (2'd2 - d_pads) : 2'd2;
                    o_push_cmd.last    = eom;
                    o_push_cmd.err     = d_bad;
                    n_bits = '0;
                    n_pads = '0;
                    if (eom) begin
                        n_bad = 1'b0;
                    end
                end
            end
        end
    end

    // Direction register and group state; a direction write drops the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DirEncode;
            r_bits <= '0;
            r_cnt  <= '0;
            r_pads <= '0;
            r_bad  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_dir  <= i_cfg_wr_data;
            r_bits <= '0;
            r_cnt  <= '0;
            r_pads <= '0;
            r_bad  <= 1'b0;
        end else begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_pads <= n_pads;
            r_bad  <= n_bad;
        end
    end

endmodule

FILE: hw/rtl/b64sc_queue.sv
module b64sc_queue
    import b64sc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_push_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    // Two-entry group queue
    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hw/rtl/b64sc_back.sv
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_head,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out_data
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out       r_out;

    logic       load;
    logic       is_final;
    logic [5:0] sext;
    logic [7:0] dbyte;
    logic       pad_pos;
    t_out       n_out;

    assign load     = !i_q_stat.empty && (!r_valid || i_out_ready);
    assign is_final = (r_idx == i_head.nres_m1);
    assign o_pop    = load && is_final;

    // Field selection for the current result
    always_comb begin
        unique case (r_idx)
            2'd0:    sext = i_head.bits[23:18];
            2'd1:    sext = i_head.bits[17:12];
            2'd2:    sext = i_head.bits[11:6];
            default: sext = i_head.bits[5:0];
        endcase
        unique case (r_idx)
            2'd0:    dbyte = i_head.bits[23:16];
            2'd1:    dbyte = i_head.bits[15:8];
            default: dbyte = i_head.bits[7:0];
        endcase
    end

    assign pad_pos = ({1'b0, r_idx} >= (3'd4 - {1'b0, i_head.pads}));

    // Build one result
    always_comb begin
        n_out.out_last = i_head.last && is_final;
        n_out.error    = i_head.err && i_head.last && is_final;
        n_out.has_data = !i_head.bad_len;
        if (i_head.bad_len) begin
            n_out.out_byte = 8'd0;
        end else if (i_head.decode == DirDecode) begin
            n_out.out_byte = dbyte;
        end else begin
            n_out.out_byte = pad_pos ? PadChar : enc_char(sext);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_final ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/base64_stream_codec_core.sv
// Base64 (standard alphabet) stream encoder / decoder.
// Input channel i_in_valid / o_in_ready / i_in_data carries one byte per transfer,
// with end_of_message set on the last byte of each message. Output channel
// o_out_valid / i_out_ready / o_out_data carries one result per transfer.
// i_cfg_wr_en / i_cfg_wr_data write the direction bit (0 encode, 1 decode);
// a write also drops any partly gathered group. Write only while idle.
// Encode: each 3 bytes give 4 characters, a short final group is padded.
// Decode: each 4 characters give up to 3 bytes; errors come on the last result.
// The group that a byte completes passes through the group queue and the output
// register before its first result is presented. Input takes one byte per cycle while
// the queue has room; output gives one result per cycle while not stalled. The output
// serializer sets the pace, so encoding is held to four characters out per three bytes
// in, while decoding takes one character per cycle. A two-entry group queue lets the
// input side keep taking bytes while the output is stalled, until both entries fill.
// Reset (i_rst_n low, synchronous) sets encode mode and empties all state.
// A stalled result stays in the output register until it is taken.
`include "base64_stream_codec_core_macros.svh"

module base64_stream_codec_core
    import b64sc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    head;
    logic    push;
    logic    pop;

    // Front end: gathers groups
    b64sc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_push_cmd   (push_cmd)
    );

    // Group queue
    b64sc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_cmd(push_cmd),
        .i_pop     (pop),
        .o_head    (head),
        .o_stat    (q_stat)
    );

    // Back end: one result per cycle while the output is not stalled
    b64sc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Checks
    `B64SC_ASSERT_NOW(a_err_on_last, i_clk, i_rst_n, o_out_valid && o_out_data.error, o_out_data.out_last, "error flagged on a result that is not the last")
    `B64SC_ASSERT_NOW(a_nodata_is_err, i_clk, i_rst_n, o_out_valid && !o_out_data.has_data, o_out_data.error && o_out_data.out_last && (o_out_data.out_byte == 8'd0), "empty result is not a length error")
    `B64SC_ASSERT_NEXT(a_full_blocks, i_clk, i_rst_n, push && q_stat.full, 1'b0, "group pushed into a full queue")

endmodule

FILE: tb/b64_codec_checker.sv
// Watches both channels of the Base64 codec, tracks its own copy of the
// codec state and compares every output transfer with the predicted element.
module b64_codec_checker
    import b64sc_pkg::*;
#(
    parameter int MAX_REPORTS = 25
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Shadow codec state
    logic        dir_mode;
    logic [23:0] grp_bits;
    logic [1:0]  grp_cnt;
    logic [1:0]  pad_cnt;
    logic        bad_seen;

    // Coded elements still to come out, oldest first
    t_out coded_out_q[$];

    int fails;
    int checked;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        fails        = 0;
        checked      = 0;
    end

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic clear_group();
        grp_bits = '0;
        grp_cnt  = '0;
        pad_cnt  = '0;
        bad_seen = 1'b0;
    endtask

    task automatic push_element(input logic [7:0] b, input logic has,
                                input logic last, input logic err);
        t_out r;
        r.out_byte = b;
        r.has_data = has;
        r.out_last = last;
        r.error    = err;
        coded_out_q = {coded_out_q, r};
    endtask

    // {bad, sextet}; bad set for anything outside the alphabet
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
        end else if (c == PlusChar) begin
            d = 8'd62;
        end else if (c == SlashChar) begin
            d = 8'd63;
        end else begin
            return {1'b1, 6'd0};
        end
        return {1'b0, d[5:0]};
    endfunction

    // Encode: three bytes (or a short final group) give four characters
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        logic [23:0] triple;
        logic [23:0] tmp;
        logic [7:0]  ch;
        int          pads;
        int          i;
        grp_bits = {grp_bits[15:0], b};
        grp_cnt  = grp_cnt + 2'd1;
        if (grp_cnt == 2'd3 || eom) begin
            triple = grp_bits << (8 * (3 - int'(grp_cnt)));
            pads   = (grp_cnt == 2'd1) ? 2 : (grp_cnt == 2'd2) ? 1 : 0;
            for (i = 0; i < 4; i++) begin
                tmp = triple >> (18 - 6 * i);
                ch  = B64_ALPHABET[8 * (63 - int'(tmp[5:0])) +: 8];
                if (i >= 4 - pads) begin
                    ch = PadChar;
                end
                push_element(ch, 1'b1, eom && (i == 3), 1'b0);
            end
            clear_group();
        end
    endtask

    // Decode: four characters give up to three bytes
    task automatic decode_char(input logic [7:0] c, input logic eom);
        logic [6:0]  s;
        logic [5:0]  v;
        logic [1:0]  pos;
        logic [23:0] tmp;
        logic        last;
        int          keep;
        int          i;
        pos = grp_cnt;
        if (c == PadChar) begin
            v = 6'd0;
            if (pos >= 2'd2) begin
                pad_cnt = pad_cnt + 2'd1;
            end
        end else begin
            s = char_sextet(c);
            v = s[5:0];
            if (s[6]) begin
                bad_seen = 1'b1;
            end
        end
        grp_bits = {grp_bits[17:0], v};
        grp_cnt  = pos + 2'd1;
        if (grp_cnt != 2'd0) begin
            // message ended inside a group: one error element, group dropped
            if (eom) begin
                push_element(8'd0, 1'b0, 1'b1, 1'b1);
                clear_group();
            end
        end else begin
            keep = eom ? 3 - int'(pad_cnt) : 3;
            for (i = 0; i < keep; i++) begin
                tmp  = grp_bits >> (16 - 8 * i);
                last = eom && (i + 1 == keep);
                push_element(tmp[7:0], 1'b1, last, last & bad_seen);
            end
            if (eom) begin
                clear_group();
            end else begin
                grp_bits = '0;
                pad_cnt  = '0;
            end
        end
    endtask

    // Compare one output transfer with the oldest prediction
    task automatic check_element(input t_out got);
        t_out want;
        if (coded_out_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h has %0b last %0b err %0b",
                                      got.out_byte, got.has_data, got.out_last, got.error));
        end else begin
            want = coded_out_q.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte) begin
                report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                          checked, got.out_byte, want.out_byte));
            end
            if (got.has_data !== want.has_data) begin
                report_mismatch($sformatf("result %0d has_data %0b, want %0b",
                                          checked, got.has_data, want.has_data));
            end
            if (got.out_last !== want.out_last) begin
                report_mismatch($sformatf("result %0d out_last %0b, want %0b",
                                          checked, got.out_last, want.out_last));
            end
            if (got.error !== want.error) begin
                report_mismatch($sformatf("result %0d error %0b, want %0b",
                                          checked, got.error, want.error));
            end
        end
    endtask

    // Per-edge monitor: config write, output check, input prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dir_mode = DirEncode;
            clear_group();
            coded_out_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                dir_mode = i_cfg_wr_data;
                clear_group();
            end
            if (i_out_valid && i_out_ready) begin
                check_element(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                if (dir_mode == DirDecode) begin
                    decode_char(i_in_data.data_byte, i_in_data.end_of_message);
                end else begin
                    encode_byte(i_in_data.data_byte, i_in_data.end_of_message);
                end
            end
        end
        o_pending    <= coded_out_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

FILE: tb/tb_top.sv
// Stimulus and verdict for the Base64 stream codec.
module tb_top;
    import b64sc_pkg::*;

    localparam int           HOLD_CYCLES   = 120;
    localparam int           IDLE_SETTLE   = 4;
    localparam int           END_SETTLE    = 8;
    localparam int           DRAIN_LIMIT   = 20000;
    localparam int           PHASE_ITEMS   = 42;
    localparam logic [511:0] B64_ALPHABET  =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int items_sent;
    int msgs_sent;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    base64_stream_codec_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_data)
    );

    b64_codec_checker u_codec_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        out_ready  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_taken != hold_requests) begin
                hold_taken = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Run limit
    initial begin
        #6000000;
        $display("FAIL");
        $finish;
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic [7:0] b, input logic eom);
        t_in x;
        x.data_byte      = b;
        x.end_of_message = eom;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (eom) begin
            msgs_sent++;
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_item(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] rand_b64_char();
        int v;
        v = $urandom_range(0, 63);
        return B64_ALPHABET[8 * (63 - v) +: 8];
    endfunction

    // Drop valid and wait until every predicted element has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_encode_msg();
        int len;
        int i;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
        for (i = 0; i < len; i++) begin
            send_item(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Whole groups of alphabet characters, final group padded 0..2
    task automatic send_clean_decode_msg();
        int         groups;
        int         pads;
        int         g;
        int         k;
        logic       last_grp;
        logic [7:0] ch;
        groups = $urandom_range(1, 3);
        pads   = $urandom_range(0, 2);
        for (g = 0; g < groups; g++) begin
            last_grp = (g == groups - 1);
            for (k = 0; k < 4; k++) begin
                ch = rand_b64_char();
                if (last_grp && k >= 4 - pads) begin
                    ch = PadChar;
                end
                send_item(ch, last_grp && k == 3);
            end
        end
    endtask

    // Length 1 to 9, stray '=' and characters outside the alphabet
    task automatic send_noisy_decode_msg();
        int         len;
        int         i;
        int         r;
        logic [7:0] ch;
        len = $urandom_range(1, 9);
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                ch = rand_b64_char();
            end else if (r < 8) begin
                ch = PadChar;
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
            send_item(ch, i == len - 1);
        end
    endtask

    // Random phase; may end on an unterminated tail that the next write drops
    task automatic run_phase(input logic dir, input int sidle, input int rstall);
        int start;
        int n;
        int i;
        wait_idle();
        write_direction(dir);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if (dir == DirEncode) begin
                send_encode_msg();
            end else if ($urandom_range(0, 99) < 75) begin
                send_clean_decode_msg();
            end else begin
                send_noisy_decode_msg();
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    initial begin
        int drain;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        items_sent     = 0;
        msgs_sent      = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed encode: full group with '+' and '/', one and two pad cases
        wait_idle();
        write_direction(DirEncode);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hBF, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'hFB, 1'b0);
        send_item(8'hEF, 1'b1);

        // Directed decode: padding, '=' early, bad char, lone pad in slot 3, short message
        wait_idle();
        write_direction(DirDecode);
        send_text("TQ==");
        send_text("+/9z");
        send_text("A=B!");
        send_text("AB=C");
        send_text("xy");

        // Output held off while input keeps coming: queue fills, input stalls
        wait_idle();
        write_direction(DirEncode);
        hold_requests++;
        for (int i = 0; i < 30; i++) begin
            send_item(8'($urandom_range(0, 255)), i == 29);
        end

        run_phase(DirEncode, 0, 0);
        run_phase(DirDecode, 0, 0);
        run_phase(DirEncode, 73, 0);
        run_phase(DirDecode, 73, 0);
        run_phase(DirEncode, 0, 73);
        run_phase(DirDecode, 0, 73);
        run_phase(DirEncode, 30, 30);
        run_phase(DirDecode, 30, 30);

        // Drain
        in_valid <= 1'b0;
        drain = 0;
        @(posedge clk);
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (END_SETTLE) @(posedge clk);

        if (pending != 0) begin
            $display("%0d predicted results never came out", pending);
        end
        $display("Covered %0d input transfers in %0d messages, encode and decode,", items_sent,
                 msgs_sent);
        $display("under idle, stall and hold-off mixes; %0d results checked", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
